// ===== hdl/regex_node_table_matcher_assert.svh =====
`ifndef REGEX_NODE_TABLE_MATCHER_ASSERT_SVH
`define REGEX_NODE_TABLE_MATCHER_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define RNTM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rntm same-cycle check failed");

// Checks that a condition implies another in the next cycle.
`define RNTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rntm next-cycle check failed");

`endif

// ===== hdl/rntm_pkg.sv =====
`default_nettype none

package rntm_pkg;

    localparam int MAX_NODES       = 16;
    localparam int NODE_IDX_BITS   = 4;
    localparam int PTR_BITS        = 5;
    localparam int CHAR_BITS       = 8;
    localparam int OUT_POS_BITS    = 16;
    localparam int GROUP_NUM_BITS  = 3;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = 5;

    localparam logic ITEM_NODE = 1'b0;
    localparam logic ITEM_CHAR = 1'b1;

    localparam logic [1:0] NK_CHAR        = 2'd0;
    localparam logic [1:0] NK_GROUP_OPEN  = 2'd1;
    localparam logic [1:0] NK_GROUP_CLOSE = 2'd2;

    localparam logic [1:0] REC_MATCH    = 2'd0;
    localparam logic [1:0] REC_GROUP    = 2'd1;
    localparam logic [1:0] REC_NO_MATCH = 2'd2;
    localparam logic [1:0] REC_OVERFLOW = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIND_ALL   = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [3:0] node_slot;
        logic [1:0] node_kind;
        logic [7:0] node_low_char;
        logic [7:0] node_high_char;
        logic       node_wildcard;
        logic       node_inverted;
        logic [3:0] jump_on_match;
        logic [3:0] jump_on_miss;
        logic [7:0] text_char;
        logic       text_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] span_start;
        logic [15:0] span_length;
        logic [2:0]  group_number;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       any;
        logic       inv;
        logic [3:0] jm;
        logic [3:0] jx;
    } t_node;

    typedef struct packed {
        logic                     is_char;
        logic [NODE_IDX_BITS-1:0] slot;
        t_node                    node;
        logic [CHAR_BITS-1:0]     ch;
        logic                     last;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT_MATCH,
        ST_EMIT_GROUP
    } t_state;

    function automatic logic char_hits(input t_node nd, input logic [CHAR_BITS-1:0] c);
        logic cond;
        if (nd.hi != '0) begin
            cond = (c >= nd.lo) && (c <= nd.hi);
        end else begin
            cond = (c == nd.lo);
        end
        return (c != '0) && (nd.any || (nd.inv ^ cond));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rntm_fifo.sv =====
`default_nettype none

module rntm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_rd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_wr_ok, w_rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr_ok = i_wr && !o_full;
    assign w_rd_ok = i_rd && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr_ok) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd_ok) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr_ok && !w_rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr_ok && w_rd_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rntm_front.sv =====
`default_nettype none

module rntm_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire rntm_pkg::t_in_item  i_item,
    output logic                     o_full,
    output logic                     o_cmd_valid,
    output rntm_pkg::t_cmd           o_cmd,
    input  wire logic                i_cmd_pop
);

    rntm_pkg::t_cmd                      w_cmd;
    logic [$bits(rntm_pkg::t_cmd)-1:0]   w_head;

    // Each word is classified and its node fields packed before it is queued.
    always_comb begin
        w_cmd.is_char = (i_item.kind == rntm_pkg::ITEM_CHAR);
        w_cmd.slot    = i_item.node_slot;
        w_cmd.node.kind = i_item.node_kind;
        w_cmd.node.lo   = i_item.node_low_char;
        w_cmd.node.hi   = i_item.node_high_char;
        w_cmd.node.any  = i_item.node_wildcard;
        w_cmd.node.inv  = i_item.node_inverted;
        w_cmd.node.jm   = i_item.jump_on_match;
        w_cmd.node.jx   = i_item.jump_on_miss;
        w_cmd.ch      = i_item.text_char;
        w_cmd.last    = i_item.text_last;
    end

    rntm_fifo #(
        .WIDTH($bits(rntm_pkg::t_cmd)),
        .DEPTH(2)
    ) u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (i_push),
        .i_data (w_cmd),
        .o_full (o_full),
        .o_valid(o_cmd_valid),
        .o_data (w_head),
        .i_rd   (i_cmd_pop)
    );

    assign o_cmd = rntm_pkg::t_cmd'(w_head);

endmodule

`default_nettype wire

// ===== hdl/rntm_back.sv =====
`default_nettype none

module rntm_back #(
    parameter int MAX_GROUPS    = 8,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [rntm_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [rntm_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire logic                                  i_cmd_valid,
    input  wire rntm_pkg::t_cmd                        i_cmd,
    output logic                                       o_cmd_pop,
    input  wire logic                                  i_out_full,
    output logic                                       o_out_wr,
    output rntm_pkg::t_out_item                        o_out_rec
);

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam int PB = POSITION_BITS;
    localparam int PW = rntm_pkg::PTR_BITS;

    rntm_pkg::t_state r_state, n_state;

    logic [PW-1:0]  r_node_count;
    logic           r_find_all;
    rntm_pkg::t_node r_table [rntm_pkg::MAX_NODES];

    logic [PW-1:0]  r_ptr, n_ptr;
    logic [PB-1:0]  r_pos, n_pos;
    logic [7:0]     r_held, n_held;
    logic           r_pending, n_pending;
    logic           r_last, n_last;
    logic           r_started, n_started;
    logic [PB-1:0]  r_begin, n_begin;
    logic [GW-1:0]  r_depth, n_depth;
    logic [CW-1:0]  r_ccount, n_ccount;
    logic           r_done, n_done;
    logic [GW-1:0]  r_gidx, n_gidx;

    logic [PB-1:0]  r_open [MAX_GROUPS];
    logic [PB-1:0]  r_cl_start [MAX_GROUPS];
    logic [PB-1:0]  r_cl_len [MAX_GROUPS];

    logic           w_tbl_we, w_open_we, w_cl_we;
    logic [PB-1:0]  w_cl_start;

    logic [PW-1:0]  w_limit;
    logic           w_at_end;
    rntm_pkg::t_node w_nd;
    logic [3:0]     w_adv;
    logic           w_is_open, w_is_close, w_overflow, w_hit, w_idle_stop;
    logic           w_last_group, w_more;
    logic           w_restart, w_rearm;
    logic [PB-1:0]  w_m_start;

    assign w_limit     = (r_node_count > PW'(rntm_pkg::MAX_NODES)) ?
                         PW'(rntm_pkg::MAX_NODES) : r_node_count;
    assign w_at_end    = (r_ptr >= w_limit);
    assign w_nd        = r_table[r_ptr[rntm_pkg::NODE_IDX_BITS-1:0]];
    assign w_adv       = (w_nd.jm != '0) ? w_nd.jm : 4'd1;
    assign w_is_open   = (w_nd.kind == rntm_pkg::NK_GROUP_OPEN);
    assign w_is_close  = (w_nd.kind == rntm_pkg::NK_GROUP_CLOSE);
    assign w_overflow  = ((CW'(r_depth) + CW'(1)) >= CW'(MAX_GROUPS));
    assign w_hit       = r_pending && rntm_pkg::char_hits(w_nd, r_held);
    assign w_idle_stop = !r_pending && !r_last;
    assign w_last_group = ((CW'(r_gidx) + CW'(1)) == r_ccount);
    assign w_more      = r_pending || !r_last;
    assign w_m_start   = r_started ? r_begin : r_pos;
    assign w_cl_start  = r_open[r_depth - 1'b1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            rntm_pkg::ST_IDLE: begin
                if (i_cmd_valid && i_cmd.is_char && !r_done) begin
                    n_state = rntm_pkg::ST_WALK;
                end
            end
            rntm_pkg::ST_WALK: begin
                if (w_at_end) begin
                    n_state = rntm_pkg::ST_EMIT_MATCH;
                end else if (w_is_open) begin
                    if (w_overflow && !i_out_full) begin
                        n_state = rntm_pkg::ST_IDLE;
                    end
                end else if (!w_is_close) begin
                    if (w_idle_stop) begin
                        n_state = rntm_pkg::ST_IDLE;
                    end else if (!w_hit && (w_nd.jx == '0) && !r_pending && !i_out_full) begin
                        n_state = rntm_pkg::ST_IDLE;
                    end
                end
            end
            rntm_pkg::ST_EMIT_MATCH: begin
                if (!i_out_full) begin
                    n_state = (r_ccount == '0) ? rntm_pkg::ST_IDLE : rntm_pkg::ST_EMIT_GROUP;
                end
            end
            rntm_pkg::ST_EMIT_GROUP: begin
                if (!i_out_full && w_last_group) begin
                    n_state = rntm_pkg::ST_IDLE;
                end
            end
            default: n_state = rntm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_held    = r_held;
        n_pending = r_pending;
        n_last    = r_last;
        n_started = r_started;
        n_begin   = r_begin;
        n_depth   = r_depth;
        n_ccount  = r_ccount;
        n_done    = r_done;
        n_gidx    = r_gidx;
        w_tbl_we  = 1'b0;
        w_open_we = 1'b0;
        w_cl_we   = 1'b0;
        w_restart = 1'b0;
        w_rearm   = 1'b0;
        o_cmd_pop = 1'b0;
        o_out_wr  = 1'b0;
        o_out_rec.record_kind  = rntm_pkg::REC_MATCH;
        o_out_rec.span_start   = rntm_pkg::OUT_POS_BITS'(r_pos);
        o_out_rec.span_length  = '0;
        o_out_rec.group_number = '0;
        o_out_rec.last         = 1'b1;
        case (r_state)
            rntm_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    if (!i_cmd.is_char) begin
                        w_tbl_we = 1'b1;
                    end else if (r_done) begin
                        w_rearm = i_cmd.last;
                    end else begin
                        n_held    = i_cmd.ch;
                        n_pending = 1'b1;
                        n_last    = i_cmd.last;
                    end
                end
            end
            rntm_pkg::ST_WALK: begin
                if (w_at_end) begin
                    n_gidx = '0;
                end else if (w_is_open) begin
                    if (w_overflow) begin
                        o_out_wr = !i_out_full;
                        o_out_rec.record_kind = rntm_pkg::REC_OVERFLOW;
                        if (!i_out_full) begin
                            w_rearm = r_last;
                            n_done  = !r_last;
                        end
                    end else begin
                        w_open_we = 1'b1;
                        n_depth   = r_depth + 1'b1;
                        n_ptr     = r_ptr + PW'(w_adv);
                    end
                end else if (w_is_close) begin
                    if (r_depth != '0) begin
                        n_depth = r_depth - 1'b1;
                        if (r_ccount < CW'(MAX_GROUPS)) begin
                            w_cl_we  = 1'b1;
                            n_ccount = r_ccount + 1'b1;
                        end
                    end
                    n_ptr = r_ptr + PW'(w_adv);
                end else if (!w_idle_stop) begin
                    if (w_hit) begin
                        if (!r_started) begin
                            n_started = 1'b1;
                            n_begin   = r_pos;
                        end
                        n_pos     = r_pos + 1'b1;
                        n_pending = 1'b0;
                        n_ptr     = r_ptr + PW'(w_nd.jm);
                    end else if (w_nd.jx == '0) begin
                        if (!r_pending) begin
                            o_out_wr = !i_out_full;
                            o_out_rec.record_kind = rntm_pkg::REC_NO_MATCH;
                            w_rearm = !i_out_full;
                        end else begin
                            if (!r_started) begin
                                n_pos     = r_pos + 1'b1;
                                n_pending = 1'b0;
                            end
                            w_restart = 1'b1;
                        end
                    end else begin
                        n_ptr = r_ptr + PW'(w_nd.jx);
                    end
                end
            end
            rntm_pkg::ST_EMIT_MATCH, rntm_pkg::ST_EMIT_GROUP: begin
                o_out_wr = !i_out_full;
                if (r_state == rntm_pkg::ST_EMIT_MATCH) begin
                    o_out_rec.span_start  = rntm_pkg::OUT_POS_BITS'(w_m_start);
                    o_out_rec.span_length = rntm_pkg::OUT_POS_BITS'(r_pos - w_m_start);
                    o_out_rec.last        = (r_ccount == '0);
                end else begin
                    o_out_rec.record_kind  = rntm_pkg::REC_GROUP;
                    o_out_rec.span_start   = rntm_pkg::OUT_POS_BITS'(r_cl_start[r_gidx]);
                    o_out_rec.span_length  = rntm_pkg::OUT_POS_BITS'(r_cl_len[r_gidx]);
                    o_out_rec.group_number = rntm_pkg::GROUP_NUM_BITS'(r_gidx);
                    o_out_rec.last         = w_last_group;
                    if (!i_out_full) begin
                        n_gidx = r_gidx + 1'b1;
                    end
                end
                if (!i_out_full && o_out_rec.last) begin
                    if (!r_find_all || !w_more) begin
                        w_rearm = r_last;
                        n_done  = !r_last;
                    end else if (r_pending) begin
                        n_pos     = r_pos + 1'b1;
                        w_rearm   = r_last;
                        w_restart = !r_last;
                    end else begin
                        w_restart = 1'b1;
                    end
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
        if (w_restart || w_rearm) begin
            n_ptr     = '0;
            n_started = 1'b0;
            n_depth   = '0;
            n_ccount  = '0;
        end
        if (w_rearm) begin
            n_pos   = '0;
            n_begin = '0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rntm_pkg::ST_IDLE;
            r_node_count <= '0;
            r_find_all   <= 1'b0;
            r_ptr        <= '0;
            r_pos        <= '0;
            r_held       <= '0;
            r_pending    <= 1'b0;
            r_last       <= 1'b0;
            r_started    <= 1'b0;
            r_begin      <= '0;
            r_depth      <= '0;
            r_ccount     <= '0;
            r_done       <= 1'b0;
            r_gidx       <= '0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_pos     <= n_pos;
            r_held    <= n_held;
            r_pending <= n_pending;
            r_last    <= n_last;
            r_started <= n_started;
            r_begin   <= n_begin;
            r_depth   <= n_depth;
            r_ccount  <= n_ccount;
            r_done    <= n_done;
            r_gidx    <= n_gidx;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rntm_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data[PW-1:0];
                    rntm_pkg::CFG_FIND_ALL:   r_find_all   <= i_cfg_data[0];
                    default:                  r_find_all   <= r_find_all;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_table[i_cmd.slot] <= i_cmd.node;
        end
        if (w_open_we) begin
            r_open[r_depth] <= r_pos;
        end
        if (w_cl_we) begin
            r_cl_start[r_ccount[GW-1:0]] <= w_cl_start;
            r_cl_len[r_ccount[GW-1:0]]   <= r_pos - w_cl_start;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/regex_node_table_matcher.sv =====
// Channel   Direction  Handshake                   Payload
// input     in         push / full                 i_item   (rntm_pkg::t_in_item)
// result    out        empty / pop                 o_record (rntm_pkg::t_out_item)
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A node write is taken by the engine in its idle state; a text character is taken from the
// input queue, then the engine visits the pattern nodes one by one, finds the end of the
// pattern on a match and sends each match or group record in turn.
// The node walk in the engine sets the rate: one node per cycle unless a record waits for result room.
// Reset is synchronous and clears all control state; the node table is undefined until written.
// Either side may stall: two-word queues sit at the input and at the result side.
`default_nettype none

`include "regex_node_table_matcher_assert.svh"

module regex_node_table_matcher #(
    parameter int MAX_GROUPS    = 8,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire rntm_pkg::t_in_item                  i_item,
    output logic                                     empty,
    input  wire logic                                pop,
    output rntm_pkg::t_out_item                      o_record,
    input  wire logic                                i_cfg_we,
    input  wire logic [rntm_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [rntm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic                                   w_cmd_valid;
    rntm_pkg::t_cmd                         w_cmd;
    logic                                   w_cmd_pop;
    logic                                   w_out_wr;
    rntm_pkg::t_out_item                    w_out_rec;
    logic                                   w_out_full;
    logic                                   w_out_valid;
    logic [$bits(rntm_pkg::t_out_item)-1:0] w_out_data;

    rntm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    rntm_back #(
        .MAX_GROUPS   (MAX_GROUPS),
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .i_out_full (w_out_full),
        .o_out_wr   (w_out_wr),
        .o_out_rec  (w_out_rec)
    );

    rntm_fifo #(
        .WIDTH($bits(rntm_pkg::t_out_item)),
        .DEPTH(2)
    ) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_out_wr),
        .i_data (w_out_rec),
        .o_full (w_out_full),
        .o_valid(w_out_valid),
        .o_data (w_out_data),
        .i_rd   (pop)
    );

    assign empty    = !w_out_valid;
    assign o_record = rntm_pkg::t_out_item'(w_out_data);

    `RNTM_ASSERT_SAME(a_out_wr_room, w_out_wr, !w_out_full)
    `RNTM_ASSERT_SAME(a_cmd_pop_valid, w_cmd_pop, w_cmd_valid)
    `RNTM_ASSERT_NEXT(a_push_queued, push && !full, w_cmd_valid)

endmodule

`default_nettype wire

// ===== bench/tb_regex_node_table_matcher.sv =====
`timescale 1ns / 100ps

module tb_regex_node_table_matcher;

    localparam int N_GROUPS = 8;
    localparam logic [1:0] NK_SPARE = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    rntm_pkg::t_in_item   i_item;
    logic                 empty;
    logic                 pop;
    rntm_pkg::t_out_item  o_record;
    logic                 i_cfg_we;
    logic [rntm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [rntm_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    regex_node_table_matcher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_record(o_record),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    rntm_pkg::t_node pat_nodes [rntm_pkg::MAX_NODES];
    logic [4:0]  pat_count;
    logic        pat_find_all;
    int          cur_node;
    logic [15:0] text_pos;
    logic        span_open;
    logic [15:0] span_begin;
    logic [15:0] open_pos [N_GROUPS];
    int          open_depth;
    logic [15:0] grp_start [N_GROUPS];
    logic [15:0] grp_len [N_GROUPS];
    int          grp_count;
    logic        search_stopped;

    rntm_pkg::t_out_item expected_records[$];
    rntm_pkg::t_out_item step_records[$];

    int error_count;
    int items_sent;
    bit no_idle;
    int pop_stall;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void restart_walk();
        cur_node = 0;
        span_open = 1'b0;
        open_depth = 0;
        grp_count = 0;
    endfunction

    function automatic void rearm_text();
        restart_walk();
        text_pos = '0;
        span_begin = '0;
        search_stopped = 1'b0;
        for (int i = 0; i < N_GROUPS; i++) begin
            open_pos[i] = '0;
            grp_start[i] = '0;
            grp_len[i] = '0;
        end
    endfunction

    function automatic void add_record(logic [1:0] k, logic [15:0] s, logic [15:0] l,
                                       logic [2:0] g);
        rntm_pkg::t_out_item r;
        r.record_kind = k;
        r.span_start = s;
        r.span_length = l;
        r.group_number = g;
        r.last = 1'b0;
        step_records.push_back(r);
    endfunction

    function automatic logic node_hits(rntm_pkg::t_node nd, logic [7:0] c);
        logic cond;
        if (c == 8'd0) return 1'b0;
        if (nd.any) return 1'b1;
        cond = (nd.hi != 8'd0) ? (c >= nd.lo && c <= nd.hi) : (c == nd.lo);
        return nd.inv ? !cond : cond;
    endfunction

    function automatic void stop_text(logic is_last);
        if (is_last) rearm_text();
        else search_stopped = 1'b1;
    endfunction

    function automatic void predict_matcher(rntm_pkg::t_in_item it);
        logic pending;
        int limit;
        logic [15:0] st;
        rntm_pkg::t_node nd;
        rntm_pkg::t_out_item r;
        step_records.delete();
        if (it.kind == rntm_pkg::ITEM_NODE) begin
            pat_nodes[it.node_slot] = '{it.node_kind, it.node_low_char, it.node_high_char,
                                        it.node_wildcard, it.node_inverted,
                                        it.jump_on_match, it.jump_on_miss};
            return;
        end
        if (search_stopped) begin
            if (it.text_last) rearm_text();
            return;
        end
        pending = 1'b1;
        limit = (pat_count < rntm_pkg::MAX_NODES) ? pat_count : rntm_pkg::MAX_NODES;
        forever begin
            if (cur_node >= limit) begin
                st = span_open ? span_begin : text_pos;
                add_record(rntm_pkg::REC_MATCH, st, text_pos - st, 3'd0);
                for (int i = 0; i < grp_count; i++)
                    add_record(rntm_pkg::REC_GROUP, grp_start[i], grp_len[i], i[2:0]);
                if (!pat_find_all || !(pending || !it.text_last)) begin
                    stop_text(it.text_last);
                end else if (pending) begin
                    text_pos = text_pos + 16'd1;
                    if (it.text_last) rearm_text();
                    else restart_walk();
                end else begin
                    restart_walk();
                end
                break;
            end
            nd = pat_nodes[cur_node];
            if (nd.kind == rntm_pkg::NK_GROUP_OPEN) begin
                if (open_depth + 1 >= N_GROUPS) begin
                    add_record(rntm_pkg::REC_OVERFLOW, text_pos, 16'd0, 3'd0);
                    stop_text(it.text_last);
                    break;
                end
                open_pos[open_depth] = text_pos;
                open_depth++;
                cur_node += (nd.jm != 0) ? nd.jm : 1;
                continue;
            end
            if (nd.kind == rntm_pkg::NK_GROUP_CLOSE) begin
                if (open_depth > 0) begin
                    open_depth--;
                    if (grp_count < N_GROUPS) begin
                        grp_start[grp_count] = open_pos[open_depth];
                        grp_len[grp_count] = text_pos - open_pos[open_depth];
                        grp_count++;
                    end
                end
                cur_node += (nd.jm != 0) ? nd.jm : 1;
                continue;
            end
            if (!pending && !it.text_last) break;
            if (pending && node_hits(nd, it.text_char)) begin
                if (!span_open) begin
                    span_open = 1'b1;
                    span_begin = text_pos;
                end
                text_pos = text_pos + 16'd1;
                pending = 1'b0;
                cur_node += nd.jm;
                continue;
            end
            if (nd.jx == 0) begin
                if (!pending) begin
                    add_record(rntm_pkg::REC_NO_MATCH, text_pos, 16'd0, 3'd0);
                    rearm_text();
                    break;
                end
                if (!span_open) begin
                    text_pos = text_pos + 16'd1;
                    pending = 1'b0;
                end
                restart_walk();
                continue;
            end
            cur_node += nd.jx;
        end
        if (step_records.size() > 0) begin
            r = step_records.pop_back();
            r.last = 1'b1;
            step_records.push_back(r);
        end
        foreach (step_records[i]) expected_records.push_back(step_records[i]);
    endfunction

    // Result checker and pop driver.
    always @(posedge i_clk) begin
        rntm_pkg::t_out_item exp_rec;
        if (i_rst_n && pop && !empty) begin
            if (expected_records.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected word: %p", o_record);
            end else begin
                exp_rec = expected_records.pop_front();
                if (o_record !== exp_rec) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Mismatch: expected %p, actual %p", exp_rec, o_record);
                end
            end
        end
        if (pop_stall > 0) begin
            pop_stall--;
            pop <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            pop_stall = $urandom_range(0, 4);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_word(rntm_pkg::t_in_item it);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_matcher(it);
        items_sent++;
    endtask

    task automatic drain_matcher();
        push <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [rntm_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [rntm_pkg::CFG_DATA_BITS-1:0] val);
        // Let queued node writes finish before the register changes.
        push <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rntm_pkg::CFG_NODE_COUNT) pat_count = val;
        else pat_find_all = val[0];
    endtask

    task automatic send_node(int slot, logic [1:0] k, logic [7:0] lo, logic [7:0] hi,
                             logic any, logic inv, logic [3:0] jm, logic [3:0] jx);
        rntm_pkg::t_in_item it;
        it = '0;
        it.kind = rntm_pkg::ITEM_NODE;
        it.node_slot = slot[3:0];
        it.node_kind = k;
        it.node_low_char = lo;
        it.node_high_char = hi;
        it.node_wildcard = any;
        it.node_inverted = inv;
        it.jump_on_match = jm;
        it.jump_on_miss = jx;
        send_word(it);
    endtask

    task automatic send_char(logic [7:0] c, logic is_last);
        rntm_pkg::t_in_item it;
        it = rntm_pkg::t_in_item'($bits(rntm_pkg::t_in_item)'({$urandom(), $urandom()}));
        it.kind = rntm_pkg::ITEM_CHAR;
        it.text_char = c;
        it.text_last = is_last;
        send_word(it);
    endtask

    task automatic test_directed();
        // Empty pattern matches at once; then stop and re-arm.
        write_cfg(rntm_pkg::CFG_NODE_COUNT, 5'd0);
        write_cfg(rntm_pkg::CFG_FIND_ALL, 5'd0);
        send_char(8'h78, 1'b0);
        send_char(8'h79, 1'b1);
        drain_matcher();
        // Nested group starts up to overflow.
        for (int i = 0; i < 8; i++)
            send_node(i, rntm_pkg::NK_GROUP_OPEN, 8'd0, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0);
        write_cfg(rntm_pkg::CFG_NODE_COUNT, 5'd8);
        send_char(8'h61, 1'b1);
        drain_matcher();
        send_node(0, rntm_pkg::NK_GROUP_OPEN, 8'd0, 8'd0, 1'b0, 1'b0, 4'd1, 4'd0);
        send_node(1, rntm_pkg::NK_CHAR, 8'h61, 8'h63, 1'b0, 1'b0, 4'd1, 4'd0);
        send_node(2, rntm_pkg::NK_GROUP_CLOSE, 8'd0, 8'd0, 1'b0, 1'b0, 4'd1, 4'd0);
        send_node(3, rntm_pkg::NK_GROUP_CLOSE, 8'd0, 8'd0, 1'b0, 1'b0, 4'd1, 4'd0);
        send_node(4, rntm_pkg::NK_CHAR, 8'h7a, 8'd0, 1'b1, 1'b1, 4'd1, 4'd0);
        send_node(5, NK_SPARE, 8'hff, 8'd0, 1'b0, 1'b0, 4'd1, 4'd1);
        send_node(6, rntm_pkg::NK_CHAR, 8'h90, 8'h20, 1'b0, 1'b1, 4'd15, 4'd15);
        write_cfg(rntm_pkg::CFG_NODE_COUNT, 5'd7);
        write_cfg(rntm_pkg::CFG_FIND_ALL, 5'd1);
        send_char(8'h62, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h63, 1'b0);
        send_char(8'h61, 1'b1);
        drain_matcher();
    endtask

    task automatic random_round();
        int n;
        int texts;
        int tlen;
        logic [7:0] lo;
        case ($urandom_range(0, 7))
            0: n = 0;
            1: n = 16;
            default: n = $urandom_range(1, 6);
        endcase
        write_cfg(rntm_pkg::CFG_NODE_COUNT, n[4:0]);
        write_cfg(rntm_pkg::CFG_FIND_ALL, 5'($urandom_range(0, 1)));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_node(i, 2'($urandom()), 8'($urandom()), 8'($urandom()),
                          1'($urandom()), 1'($urandom()), 4'($urandom()), 4'($urandom()));
            end else if ($urandom_range(0, 5) == 0) begin
                send_node(i, 2'($urandom_range(1, 2)), 8'd0, 8'd0, 1'b0, 1'b0,
                          4'($urandom_range(0, 1)), 4'd0);
            end else begin
                lo = 8'h61 + 8'($urandom_range(0, 2));
                send_node(i, rntm_pkg::NK_CHAR, lo,
                          ($urandom_range(0, 3) == 0) ? lo + 8'd1 : 8'd0,
                          $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                          ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 2)) : 4'd1,
                          ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 2)) : 4'd0);
            end
        end
        texts = $urandom_range(1, 3);
        for (int t = 0; t < texts; t++) begin
            tlen = $urandom_range(1, 12);
            for (int k = 0; k < tlen; k++)
                send_char(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                      : 8'h61 + 8'($urandom_range(0, 2)),
                          k == tlen - 1);
        end
        drain_matcher();
    endtask

    task automatic test_random_idle();
        while (items_sent < 280) random_round();
    endtask

    task automatic test_random_no_idle();
        no_idle = 1'b1;
        while (items_sent < 350) random_round();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        error_count = 0;
        items_sent = 0;
        no_idle = 1'b0;
        pop_stall = 0;
        pat_count = '0;
        pat_find_all = 1'b0;
        for (int i = 0; i < rntm_pkg::MAX_NODES; i++) pat_nodes[i] = '0;
        rearm_text();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_idle();
        test_random_no_idle();
        drain_matcher();
        if (error_count == 0 && expected_records.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rntm_pkg.sv
hdl/rntm_fifo.sv
hdl/rntm_front.sv
hdl/rntm_back.sv
hdl/regex_node_table_matcher.sv
bench/tb_regex_node_table_matcher.sv
